>>> design/mtlsd_pkg.sv
// Shared types, constants and register codes of the MMIO trap load/store decoder.
`default_nettype none
package mtlsd_pkg;

    localparam int APERTURE_COUNT = 3;
    localparam int AP_IDX_W       = 2;
    localparam int XLEN           = 64;
    localparam int CPU_W          = 8;
    localparam int SIZE_W         = 4;
    localparam int REG_W          = 5;
    localparam int STEP_W         = 3;
    localparam int INSN_W         = 32;

    localparam int PADDR_W        = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int S_TDATA_W      = 176;
    localparam int M_TDATA_W      = 88;

    localparam logic [CFG_IDX_W-1:0] REG_AP_LAST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MBOX    = 3'd6;

    localparam logic       CMD_FAULT  = 1'b0;
    localparam logic       CMD_RETURN = 1'b1;

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [1:0] QUAD_C0    = 2'b00;
    localparam logic [1:0] QUAD_BASE  = 2'b11;

    localparam logic [STEP_W-1:0] STEP_RVC  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_BASE = 3'd4;
    localparam logic [STEP_W-1:0] STEP_NONE = 3'd0;

    typedef struct packed {
        logic [APERTURE_COUNT-1:0][XLEN-1:0] base;
        logic [APERTURE_COUNT-1:0][XLEN-1:0] size;
        logic [CPU_W-1:0]                    mbox_count;
    } t_cfg;

    typedef struct packed {
        logic              cmd;
        logic [INSN_W-1:0] insn;
        logic [XLEN-1:0]   fault_addr;
        logic              dir_write;
        logic [CPU_W-1:0]  cpu_id;
        logic [XLEN-1:0]   read_data;
    } t_in_item;

    typedef struct packed {
        logic                                cmd;
        logic [XLEN-1:0]                     read_data;
        logic                                dir_write;
        logic                                cpu_ok;
        logic [STEP_W-1:0]                   len;
        logic                                store;
        logic [SIZE_W-1:0]                   size;
        logic [REG_W-1:0]                    dreg;
        logic                                sgn;
        logic [APERTURE_COUNT-1:0]           ge;
        logic [APERTURE_COUNT-1:0][XLEN-1:0] off;
    } t_stage2;

    typedef struct packed {
        logic                handled;
        logic                store_access;
        logic [SIZE_W-1:0]   access_size;
        logic [REG_W-1:0]    data_reg;
        logic [STEP_W-1:0]   pc_step;
        logic [AP_IDX_W-1:0] aperture_hit;
        logic                writeback_valid;
        logic [REG_W-1:0]    writeback_reg;
        logic [XLEN-1:0]     writeback_value;
    } t_result;

endpackage
`default_nettype wire

>>> design/mtlsd_cfg.sv
// APB register file holding the aperture windows and the mailbox count.
`default_nettype none
module mtlsd_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mtlsd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mtlsd_pkg::XLEN-1:0]      pwdata,
    output logic      [mtlsd_pkg::XLEN-1:0]      prdata,
    output logic                                 pready,
    output mtlsd_pkg::t_cfg                      o_cfg
);
    import mtlsd_pkg::*;

    logic [APERTURE_COUNT-1:0][XLEN-1:0] r_base;
    logic [APERTURE_COUNT-1:0][XLEN-1:0] r_size;
    logic [CPU_W-1:0]                    r_mbox;
    logic [CFG_IDX_W-1:0]                idx;
    logic [AP_IDX_W-1:0]                 ap_sel;
    logic                                wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[PADDR_W-1:PADDR_W-CFG_IDX_W];
    assign ap_sel = idx[CFG_IDX_W-1:1];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_size <= '0;
            r_mbox <= '0;
        end else if (wr_en) begin
            for (int i = 0; i < APERTURE_COUNT; i++) begin
                if (idx <= REG_AP_LAST && ap_sel == AP_IDX_W'(i)) begin
                    if (idx[0]) begin
                        r_size[i] <= pwdata;
                    end else begin
                        r_base[i] <= pwdata;
                    end
                end
            end
            if (idx == REG_MBOX) begin
                r_mbox <= pwdata[CPU_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (idx <= REG_AP_LAST) begin
            for (int i = 0; i < APERTURE_COUNT; i++) begin
                if (ap_sel == AP_IDX_W'(i)) begin
                    prdata = idx[0] ? r_size[i] : r_base[i];
                end
            end
        end else if (idx == REG_MBOX) begin
            prdata = {{(XLEN-CPU_W){1'b0}}, r_mbox};
        end
    end

    assign o_cfg.base       = r_base;
    assign o_cfg.size       = r_size;
    assign o_cfg.mbox_count = r_mbox;

endmodule
`default_nettype wire

>>> design/mtlsd_match.sv
// Decode stage: instruction decode, aperture offsets and CPU index check.
`default_nettype none
module mtlsd_match (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire mtlsd_pkg::t_cfg      i_cfg,
    input  wire logic                 i_valid,
    input  wire mtlsd_pkg::t_in_item  i_item,
    output logic                      o_ready,
    output logic                      o_valid,
    output mtlsd_pkg::t_stage2        o_stage,
    input  wire logic                 i_ready
);
    import mtlsd_pkg::*;

    localparam logic [2:0] C_LW = 3'd2;
    localparam logic [2:0] C_LD = 3'd3;
    localparam logic [2:0] C_SW = 3'd6;
    localparam logic [2:0] C_SD = 3'd7;
    localparam logic [2:0] F3_B  = 3'd0;
    localparam logic [2:0] F3_H  = 3'd1;
    localparam logic [2:0] F3_W  = 3'd2;
    localparam logic [2:0] F3_D  = 3'd3;
    localparam logic [2:0] F3_BU = 3'd4;
    localparam logic [2:0] F3_HU = 3'd5;
    localparam logic [2:0] F3_WU = 3'd6;

    logic               r_valid;
    t_stage2            r_stage;
    t_stage2            n_stage;
    logic [INSN_W-1:0]  w;
    logic [2:0]         cf3;
    logic [2:0]         f3;
    logic [XLEN:0]      diff;

    assign w   = i_item.insn;
    assign cf3 = w[15:13];
    assign f3  = w[14:12];

    always_comb begin
        n_stage           = '0;
        n_stage.cmd       = i_item.cmd;
        n_stage.read_data = i_item.read_data;
        n_stage.dir_write = i_item.dir_write;
        n_stage.cpu_ok    = i_item.cpu_id < i_cfg.mbox_count;
        diff              = '0;
        for (int i = 0; i < APERTURE_COUNT; i++) begin
            diff              = {1'b0, i_item.fault_addr} - {1'b0, i_cfg.base[i]};
            n_stage.off[i]    = diff[XLEN-1:0];
            n_stage.ge[i]     = !diff[XLEN];
        end
        if (w[1:0] == QUAD_C0) begin
            n_stage.dreg = REG_W'(5'd8 + {2'b00, w[4:2]});
            unique case (cf3)
                C_LW: begin
                    n_stage.len = STEP_RVC; n_stage.size = 4'd4; n_stage.sgn = 1'b1;
                end
                C_LD: begin
                    n_stage.len = STEP_RVC; n_stage.size = 4'd8;
                end
                C_SW: begin
                    n_stage.len = STEP_RVC; n_stage.size = 4'd4; n_stage.store = 1'b1;
                end
                C_SD: begin
                    n_stage.len = STEP_RVC; n_stage.size = 4'd8; n_stage.store = 1'b1;
                end
                default: n_stage.len = STEP_NONE;
            endcase
        end else if (w[1:0] == QUAD_BASE && w[6:0] == OPC_LOAD) begin
            n_stage.dreg = w[11:7];
            n_stage.len  = STEP_BASE;
            unique case (f3)
                F3_B:  begin n_stage.size = 4'd1; n_stage.sgn = 1'b1; end
                F3_H:  begin n_stage.size = 4'd2; n_stage.sgn = 1'b1; end
                F3_W:  begin n_stage.size = 4'd4; n_stage.sgn = 1'b1; end
                F3_D:  n_stage.size = 4'd8;
                F3_BU: n_stage.size = 4'd1;
                F3_HU: n_stage.size = 4'd2;
                F3_WU: n_stage.size = 4'd4;
                default: n_stage.len = STEP_NONE;
            endcase
        end else if (w[1:0] == QUAD_BASE && w[6:0] == OPC_STORE) begin
            n_stage.dreg  = w[24:20];
            n_stage.len   = STEP_BASE;
            n_stage.store = 1'b1;
            unique case (f3)
                F3_B: n_stage.size = 4'd1;
                F3_H: n_stage.size = 4'd2;
                F3_W: n_stage.size = 4'd4;
                F3_D: n_stage.size = 4'd8;
                default: n_stage.len = STEP_NONE;
            endcase
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
`default_nettype wire

>>> design/mtlsd_resolve.sv
// Resolve stage: aperture pick, fit check, pending load state and result register.
`default_nettype none
module mtlsd_resolve (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire mtlsd_pkg::t_cfg      i_cfg,
    input  wire logic                 i_valid,
    input  wire mtlsd_pkg::t_stage2   i_stage,
    output logic                      o_ready,
    output logic                      o_valid,
    output mtlsd_pkg::t_result        o_result,
    input  wire logic                 i_ready
);
    import mtlsd_pkg::*;

    logic                r_valid;
    t_result             r_result;
    t_result             n_result;
    logic                r_pend;
    logic [SIZE_W-1:0]   r_pend_size;
    logic                r_pend_sgn;
    logic [REG_W-1:0]    r_pend_reg;
    logic                n_pend;
    logic [SIZE_W-1:0]   n_pend_size;
    logic                n_pend_sgn;
    logic [REG_W-1:0]    n_pend_reg;
    logic                found;
    logic [AP_IDX_W-1:0] hit;
    logic [XLEN-1:0]     rem;
    logic [XLEN-1:0]     rem_i;
    logic                fit;
    logic                handled;
    logic [XLEN-1:0]     mask;
    logic                top;
    logic                take;

    always_comb begin
        found = 1'b0;
        hit   = '0;
        rem   = '0;
        rem_i = '0;
        for (int i = APERTURE_COUNT - 1; i >= 0; i--) begin
            rem_i = i_cfg.size[i] - i_stage.off[i];
            if (i_cfg.size[i] != '0 && i_stage.ge[i] && i_stage.off[i] < i_cfg.size[i]) begin
                found = 1'b1;
                hit   = AP_IDX_W'(i);
                rem   = rem_i;
            end
        end
    end

    assign fit     = rem >= {{(XLEN-SIZE_W){1'b0}}, i_stage.size};
    assign handled = found && i_stage.cpu_ok && i_stage.len != STEP_NONE
                     && i_stage.store == i_stage.dir_write && fit;

    always_comb begin
        case (r_pend_size)
            4'd1:    mask = 64'h0000_0000_0000_00ff;
            4'd2:    mask = 64'h0000_0000_0000_ffff;
            4'd4:    mask = 64'h0000_0000_ffff_ffff;
            default: mask = '1;
        endcase
        case (r_pend_size)
            4'd1:    top = i_stage.read_data[7];
            4'd2:    top = i_stage.read_data[15];
            4'd4:    top = i_stage.read_data[31];
            default: top = 1'b0;
        endcase
    end

    always_comb begin
        n_result    = '0;
        n_pend      = r_pend;
        n_pend_size = r_pend_size;
        n_pend_sgn  = r_pend_sgn;
        n_pend_reg  = r_pend_reg;
        if (i_stage.cmd == CMD_RETURN) begin
            if (r_pend) begin
                if (r_pend_reg != '0) begin
                    n_result.writeback_valid = 1'b1;
                    n_result.writeback_reg   = r_pend_reg;
                    n_result.writeback_value = (i_stage.read_data & mask)
                                               | ((r_pend_sgn && top) ? ~mask : '0);
                end
                n_pend = 1'b0;
            end
        end else if (handled) begin
            n_result.handled      = 1'b1;
            n_result.store_access = i_stage.store;
            n_result.access_size  = i_stage.size;
            n_result.data_reg     = i_stage.dreg;
            n_result.pc_step      = i_stage.len;
            n_result.aperture_hit = hit;
            n_pend                = !i_stage.store;
            if (!i_stage.store) begin
                n_pend_size = i_stage.size;
                n_pend_sgn  = i_stage.sgn;
                n_pend_reg  = i_stage.dreg;
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign take    = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_size <= '0;
            r_pend_sgn  <= 1'b0;
            r_pend_reg  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_pend      <= n_pend;
                r_pend_size <= n_pend_size;
                r_pend_sgn  <= n_pend_sgn;
                r_pend_reg  <= n_pend_reg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

>>> design/mmio_trap_load_store_decoder.sv
// Top level of the MMIO trap load/store decoder with stream and APB ports.
`default_nettype none
// Each transfer on the slave stream is either a fault to decode (tuser = 0) or the raw
// data returned by a device read (tuser = 1). A fault is matched against the first enabled
// aperture holding the address, its RV64 or RVC quadrant-0 load/store is decoded, and one
// result transfer reports whether it is handled, the access, its register and PC step; a
// handled load is kept until the next read return (a handled store drops it), whose result
// carries the widened register writeback unless its register is x0. One transfer is taken every
// cycle while the output is not stalled; each passes an input, a decode and a result register.
module mmio_trap_load_store_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // insn[31:0], fault_addr[95:32], dir_write[96], cpu_id[104:97], read_data[168:105]
    input  wire logic [mtlsd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // cmd[0]
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // handled[0], store_access[1], access_size[5:2], data_reg[10:6], pc_step[13:11],
    // aperture_hit[15:14], writeback_valid[16], writeback_reg[21:17],
    // writeback_value[85:22]
    output logic      [mtlsd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mtlsd_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [mtlsd_pkg::XLEN-1:0]        pwdata,
    output logic      [mtlsd_pkg::XLEN-1:0]        prdata,
    output logic                                   pready
);
    import mtlsd_pkg::*;

    t_cfg     cfg;
    logic     r_in_valid;
    t_in_item r_in;
    t_in_item n_in;
    logic     m_ready;
    logic     m_valid;
    t_stage2  m_stage;
    logic     v_ready;
    t_result  res;

    mtlsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign n_in.cmd        = s_axis_tuser;
    assign n_in.insn       = s_axis_tdata[31:0];
    assign n_in.fault_addr = s_axis_tdata[95:32];
    assign n_in.dir_write  = s_axis_tdata[96];
    assign n_in.cpu_id     = s_axis_tdata[104:97];
    assign n_in.read_data  = s_axis_tdata[168:105];

    assign s_axis_tready = !r_in_valid || m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= n_in;
        end
    end

    mtlsd_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (r_in_valid),
        .i_item  (r_in),
        .o_ready (m_ready),
        .o_valid (m_valid),
        .o_stage (m_stage),
        .i_ready (v_ready)
    );

    mtlsd_resolve u_resolve (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (m_valid),
        .i_stage  (m_stage),
        .o_ready  (v_ready),
        .o_valid  (m_axis_tvalid),
        .o_result (res),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, res.writeback_value, res.writeback_reg,
                           res.writeback_valid, res.aperture_hit, res.pc_step,
                           res.data_reg, res.access_size, res.store_access, res.handled};

endmodule
`default_nettype wire

>>> sim/mmio_trap_load_store_decoder_test.sv
// Self-checking stream and APB testbench for the MMIO trap load/store decoder.
module mmio_trap_load_store_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mtlsd_pkg::*;

    localparam int LATENCY     = 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 80;

    typedef enum int {
        CR_AP0_BASE, CR_AP0_SIZE, CR_AP1_BASE, CR_AP1_SIZE, CR_AP2_BASE, CR_AP2_SIZE, CR_MBOX
    } t_cfg_reg;

    localparam logic [2:0] F3_B   = 3'd0;
    localparam logic [2:0] F3_H   = 3'd1;
    localparam logic [2:0] F3_W   = 3'd2;
    localparam logic [2:0] F3_D   = 3'd3;
    localparam logic [2:0] F3_BU  = 3'd4;
    localparam logic [2:0] F3_HU  = 3'd5;
    localparam logic [2:0] F3_WU  = 3'd6;
    localparam logic [2:0] F3_BAD = 3'd7;
    localparam logic [2:0] CF3_LW = 3'd2;
    localparam logic [2:0] CF3_LD = 3'd3;
    localparam logic [2:0] CF3_SW = 3'd6;
    localparam logic [2:0] CF3_SD = 3'd7;
    localparam logic [1:0] QUAD_C1 = 2'b01;

    localparam logic [XLEN-1:0] A0_BASE = 64'h0000_0000_4000_0000;
    localparam logic [XLEN-1:0] A0_SIZE = 64'h0000_0000_0000_1000;
    localparam logic [XLEN-1:0] A1_BASE = 64'h0000_0000_8000_0000;
    localparam logic [XLEN-1:0] A1_SIZE = 64'h0000_0000_0000_0010;
    localparam logic [XLEN-1:0] A2_BASE = 64'hFFFF_FFFF_FFFF_FF00;
    localparam logic [XLEN-1:0] A2_SIZE = 64'h0000_0000_0000_0100;

    typedef struct {
        t_in_item stim;
        bit       pinned;
        t_result  want;
    } t_plan_row;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [XLEN-1:0]      pwdata        = '0;
    logic [XLEN-1:0]      prdata;
    logic                 pready;

    logic [XLEN-1:0]  win_base [APERTURE_COUNT];
    logic [XLEN-1:0]  win_size [APERTURE_COUNT];
    logic [CPU_W-1:0] mbox_limit;
    logic             load_open;
    logic [SIZE_W-1:0] load_size;
    logic             load_signed;
    logic [REG_W-1:0] load_reg;

    logic [XLEN-1:0] cfg_words [7];
    t_result         trap_outcomes [$];
    t_result         seen;
    t_result         due;
    int              mismatches     = 0;
    int              cycles         = 0;
    bit              sender_idles   = 1'b1;
    bit              receiver_idles = 1'b1;

    mmio_trap_load_store_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [XLEN-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [XLEN-1:0] mbox_word(input logic [CPU_W-1:0] m);
        return {$urandom, 24'($urandom), m};
    endfunction

    function automatic logic [31:0] i_load(input logic [2:0] f3, input logic [4:0] rd);
        return {12'hA5C, 5'd10, f3, rd, OPC_LOAD};
    endfunction

    function automatic logic [31:0] i_store(input logic [2:0] f3, input logic [4:0] rs2);
        return {7'h2B, rs2, 5'd11, f3, 5'h15, OPC_STORE};
    endfunction

    function automatic logic [31:0] i_rvc(input logic [2:0] f3, input logic [2:0] rdp,
                                          input logic [1:0] quad);
        return {16'hC3A5, f3, 3'b101, 3'b010, 2'b11, rdp, quad};
    endfunction

    function automatic t_in_item fault(input logic [31:0] w, input logic [XLEN-1:0] addr,
                                       input logic wr, input logic [CPU_W-1:0] cpu);
        t_in_item it;
        it.cmd        = CMD_FAULT;
        it.insn       = w;
        it.fault_addr = addr;
        it.dir_write  = wr;
        it.cpu_id     = cpu;
        it.read_data  = rand64();
        return it;
    endfunction

    function automatic t_in_item ret(input logic [XLEN-1:0] data);
        t_in_item it;
        it.cmd        = CMD_RETURN;
        it.insn       = $urandom;
        it.fault_addr = rand64();
        it.dir_write  = 1'($urandom);
        it.cpu_id     = 8'($urandom);
        it.read_data  = data;
        return it;
    endfunction

    function automatic t_result res(input logic h, input logic st, input logic [SIZE_W-1:0] sz,
                                    input logic [REG_W-1:0] rg, input logic [STEP_W-1:0] step,
                                    input logic [AP_IDX_W-1:0] hit, input logic wbv,
                                    input logic [REG_W-1:0] wbr, input logic [XLEN-1:0] wbval);
        t_result r;
        r.handled         = h;
        r.store_access    = st;
        r.access_size     = sz;
        r.data_reg        = rg;
        r.pc_step         = step;
        r.aperture_hit    = hit;
        r.writeback_valid = wbv;
        r.writeback_reg   = wbr;
        r.writeback_value = wbval;
        return r;
    endfunction

    function automatic t_plan_row free_row(input t_in_item it);
        t_plan_row r;
        r.stim   = it;
        r.pinned = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic t_plan_row pinned_row(input t_in_item it, input t_result want);
        t_plan_row r;
        r.stim   = it;
        r.pinned = 1'b1;
        r.want   = want;
        return r;
    endfunction

    function automatic logic [XLEN-1:0] widen_load(input logic [XLEN-1:0] raw,
                                                   input logic [SIZE_W-1:0] sz,
                                                   input logic sgn);
        case (sz)
            4'd1:    return {{56{sgn & raw[7]}}, raw[7:0]};
            4'd2:    return {{48{sgn & raw[15]}}, raw[15:0]};
            4'd4:    return {{32{sgn & raw[31]}}, raw[31:0]};
            default: return raw;
        endcase
    endfunction

    // Works out the result of one transfer and advances the pending-load state.
    function automatic t_result decode_trap(input t_in_item it);
        t_result           r;
        logic              found;
        int                hit;
        logic [XLEN-1:0]   off;
        logic [STEP_W-1:0] len;
        logic              st;
        logic              sgn;
        logic [SIZE_W-1:0] sz;
        logic [REG_W-1:0]  rg;
        r     = '0;
        found = 1'b0;
        hit   = 0;
        off   = '0;
        len   = STEP_NONE;
        st    = 1'b0;
        sgn   = 1'b0;
        sz    = '0;
        rg    = '0;
        if (it.cmd == CMD_RETURN) begin
            if (load_open && load_reg != '0) begin
                r.writeback_valid = 1'b1;
                r.writeback_reg   = load_reg;
                r.writeback_value = widen_load(it.read_data, load_size, load_signed);
            end
            load_open = 1'b0;
            return r;
        end
        for (int i = 0; i < APERTURE_COUNT; i++) begin
            if (!found && win_size[i] != '0 && it.fault_addr >= win_base[i] &&
                it.fault_addr - win_base[i] < win_size[i]) begin
                found = 1'b1;
                hit   = i;
                off   = it.fault_addr - win_base[i];
            end
        end
        if (!found || it.cpu_id >= mbox_limit) return r;
        if (it.insn[1:0] == QUAD_C0) begin
            rg  = {2'b01, it.insn[4:2]};
            len = STEP_RVC;
            case (it.insn[15:13])
                CF3_LW: begin sz = 4'd4; sgn = 1'b1; end
                CF3_LD: sz = 4'd8;
                CF3_SW: begin st = 1'b1; sz = 4'd4; end
                CF3_SD: begin st = 1'b1; sz = 4'd8; end
                default: len = STEP_NONE;
            endcase
        end else if (it.insn[6:0] == OPC_LOAD) begin
            rg  = it.insn[11:7];
            len = STEP_BASE;
            case (it.insn[14:12])
                F3_B:  begin sz = 4'd1; sgn = 1'b1; end
                F3_H:  begin sz = 4'd2; sgn = 1'b1; end
                F3_W:  begin sz = 4'd4; sgn = 1'b1; end
                F3_D:  sz = 4'd8;
                F3_BU: sz = 4'd1;
                F3_HU: sz = 4'd2;
                F3_WU: sz = 4'd4;
                default: len = STEP_NONE;
            endcase
        end else if (it.insn[6:0] == OPC_STORE) begin
            st  = 1'b1;
            rg  = it.insn[24:20];
            len = STEP_BASE;
            case (it.insn[14:12])
                F3_B: sz = 4'd1;
                F3_H: sz = 4'd2;
                F3_W: sz = 4'd4;
                F3_D: sz = 4'd8;
                default: len = STEP_NONE;
            endcase
        end
        if (len == STEP_NONE || st != it.dir_write || XLEN'(sz) > win_size[hit] - off) return r;
        r.handled      = 1'b1;
        r.store_access = st;
        r.access_size  = sz;
        r.data_reg     = rg;
        r.pc_step      = len;
        r.aperture_hit = AP_IDX_W'(hit);
        if (st) begin
            load_open = 1'b0;
        end else begin
            load_open   = 1'b1;
            load_size   = sz;
            load_signed = sgn;
            load_reg    = rg;
        end
        return r;
    endfunction

    // Mostly decodable accesses aimed at an aperture, with read returns and raw noise.
    function automatic t_in_item next_trap_item();
        int               pick;
        int               win;
        logic [XLEN-1:0]  off;
        logic [XLEN-1:0]  addr;
        logic [31:0]      w;
        logic             wr;
        logic [CPU_W-1:0] cpu;
        pick = $urandom_range(0, 99);
        if (pick < 30) return ret(rand64());
        w    = $urandom;
        addr = rand64();
        wr   = 1'($urandom);
        cpu  = 8'($urandom);
        if (pick >= 88) return fault(w, addr, wr, cpu);
        win = $urandom_range(0, APERTURE_COUNT - 1);
        if (win_size[win] != '0) begin
            if ($urandom_range(0, 1) == 0) off = XLEN'($urandom_range(0, 15));
            else off = win_size[win] - XLEN'($urandom_range(1, 16));
            if (off >= win_size[win]) off = win_size[win] - 1;
            addr = win_base[win] + off;
        end
        case ($urandom_range(0, 2))
            0: begin
                w[6:0]   = OPC_LOAD;
                w[14:12] = ($urandom_range(0, 9) == 0) ? F3_BAD : 3'($urandom_range(0, 6));
                wr       = 1'b0;
            end
            1: begin
                w[6:0]   = OPC_STORE;
                w[14:12] = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                                       : 3'($urandom_range(0, 3));
                wr       = 1'b1;
            end
            default: begin
                w[1:0]   = QUAD_C0;
                w[15:13] = ($urandom_range(0, 4) == 0) ? 3'($urandom)
                                                       : {1'($urandom), 1'b1, 1'($urandom)};
                wr       = w[15];
            end
        endcase
        if ($urandom_range(0, 9) == 0) wr = ~wr;
        if (mbox_limit != '0 && $urandom_range(0, 9) != 0)
            cpu = 8'($urandom_range(0, mbox_limit - 1));
        return fault(w, addr, wr, cpu);
    endfunction

    task automatic check_field(input string name, input logic [XLEN-1:0] want,
                               input logic [XLEN-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input t_in_item it, input bit pinned, input t_result want);
        t_result predicted;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {7'b0, it.read_data, it.cpu_id, it.dir_write, it.fault_addr,
                          it.insn};
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        predicted = decode_trap(it);
        trap_outcomes.push_back(pinned ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (trap_outcomes.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic program_windows();
        for (int idx = 0; idx <= CR_MBOX; idx++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= PADDR_W'(8 * idx);
            pwdata  <= cfg_words[idx];
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (pready !== 1'b1) @(posedge i_clk);
            if (idx == CR_MBOX) mbox_limit = cfg_words[idx][CPU_W-1:0];
            else if (idx % 2 == 0) win_base[idx / 2] = cfg_words[idx];
            else win_size[idx / 2] = cfg_words[idx];
            @(negedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (trap_outcomes.size() == 0) begin
                $error("result transfer with no outcome outstanding");
                mismatches++;
            end else begin
                due                  = trap_outcomes.pop_front();
                seen.handled         = m_axis_tdata[0];
                seen.store_access    = m_axis_tdata[1];
                seen.access_size     = m_axis_tdata[5:2];
                seen.data_reg        = m_axis_tdata[10:6];
                seen.pc_step         = m_axis_tdata[13:11];
                seen.aperture_hit    = m_axis_tdata[15:14];
                seen.writeback_valid = m_axis_tdata[16];
                seen.writeback_reg   = m_axis_tdata[21:17];
                seen.writeback_value = m_axis_tdata[85:22];
                check_field("handled", XLEN'(due.handled), XLEN'(seen.handled));
                check_field("store_access", XLEN'(due.store_access), XLEN'(seen.store_access));
                check_field("access_size", XLEN'(due.access_size), XLEN'(seen.access_size));
                check_field("data_reg", XLEN'(due.data_reg), XLEN'(seen.data_reg));
                check_field("pc_step", XLEN'(due.pc_step), XLEN'(seen.pc_step));
                check_field("aperture_hit", XLEN'(due.aperture_hit), XLEN'(seen.aperture_hit));
                check_field("writeback_valid", XLEN'(due.writeback_valid),
                            XLEN'(seen.writeback_valid));
                check_field("writeback_reg", XLEN'(due.writeback_reg),
                            XLEN'(seen.writeback_reg));
                check_field("writeback_value", due.writeback_value, seen.writeback_value);
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (receiver_idles && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        t_plan_row       plan [$];
        logic [XLEN-1:0] span;
        for (int i = 0; i < APERTURE_COUNT; i++) begin
            win_base[i] = '0;
            win_size[i] = '0;
        end
        mbox_limit  = '0;
        load_open   = 1'b0;
        load_size   = '0;
        load_signed = 1'b0;
        load_reg    = '0;

        plan.push_back(pinned_row(fault(i_store(F3_D, 5'd31), A0_BASE, 1'b1, 8'd0), '0));
        plan.push_back(pinned_row(ret(64'hFFFF_FFFF_FFFF_FFFF), '0));
        plan.push_back(pinned_row(fault(i_store(F3_D, 5'd31), A0_BASE, 1'b1, 8'd0),
                                  res(1'b1, 1'b1, 4'd8, 5'd31, STEP_BASE, 2'd0, 1'b0, 5'd0,
                                      64'h0)));
        plan.push_back(free_row(fault(i_load(F3_B, 5'd5), A0_BASE + 1, 1'b0, 8'd3)));
        plan.push_back(pinned_row(ret(64'h1234_5678_9ABC_DE80),
                                  res(1'b0, 1'b0, 4'd0, 5'd0, STEP_NONE, 2'd0, 1'b1, 5'd5,
                                      64'hFFFF_FFFF_FFFF_FF80)));
        plan.push_back(free_row(fault(i_load(F3_HU, 5'd6), A1_BASE + 14, 1'b0, 8'd1)));
        plan.push_back(free_row(ret(64'hFFFF_FFFF_FFFF_8001)));
        plan.push_back(free_row(fault(i_load(F3_H, 5'd7), A0_BASE + 2, 1'b0, 8'd2)));
        plan.push_back(free_row(fault(i_load(F3_WU, 5'd8), A0_BASE + 4, 1'b0, 8'd2)));
        plan.push_back(free_row(ret(64'h8000_0000_8000_0000)));
        plan.push_back(free_row(fault(i_load(F3_D, 5'd10), 64'hFFFF_FFFF_FFFF_FFF8, 1'b0,
                                      8'd3)));
        plan.push_back(free_row(fault(i_store(F3_W, 5'd1), A0_BASE + 16, 1'b1, 8'd0)));
        plan.push_back(pinned_row(ret(rand64()), '0));
        plan.push_back(free_row(fault(i_load(F3_BU, 5'd0), A0_BASE, 1'b0, 8'd0)));
        plan.push_back(pinned_row(ret(64'h0000_0000_0000_00FF), '0));
        plan.push_back(free_row(fault(i_store(F3_B, 5'd3), A2_BASE, 1'b1, 8'd1)));
        plan.push_back(free_row(fault(i_store(F3_H, 5'd4), A1_BASE, 1'b1, 8'd1)));
        plan.push_back(free_row(fault(i_rvc(CF3_LW, 3'd7, QUAD_C0), A0_BASE + 32, 1'b0, 8'd0)));
        plan.push_back(free_row(ret(64'h0000_0000_FFFF_FFFF)));
        plan.push_back(free_row(fault(i_rvc(CF3_LD, 3'd0, QUAD_C0), A0_BASE, 1'b0, 8'd0)));
        plan.push_back(free_row(fault(i_rvc(CF3_SW, 3'd1, QUAD_C0), A0_BASE, 1'b1, 8'd0)));
        plan.push_back(free_row(fault(i_rvc(CF3_SD, 3'd2, QUAD_C0), A0_BASE, 1'b1, 8'd0)));
        plan.push_back(pinned_row(fault(i_load(F3_D, 5'd1), A0_BASE, 1'b0, 8'd4), '0));
        plan.push_back(pinned_row(fault(i_load(F3_BAD, 5'd1), A0_BASE, 1'b0, 8'd0), '0));
        plan.push_back(pinned_row(fault(i_rvc(CF3_LW, 3'd1, QUAD_C1), A0_BASE, 1'b0, 8'd0),
                                  '0));
        plan.push_back(pinned_row(fault(i_load(F3_D, 5'd1), A0_BASE, 1'b1, 8'd0), '0));
        plan.push_back(pinned_row(fault(i_load(F3_D, 5'd1), A1_BASE + 12, 1'b0, 8'd0), '0));
        plan.push_back(pinned_row(fault(i_load(F3_D, 5'd1), 64'h0, 1'b0, 8'd0), '0));
        plan.push_back(pinned_row(ret(rand64()), '0));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k]) begin
            if (k == 2) begin
                settle();
                cfg_words = '{A0_BASE, A0_SIZE, A1_BASE, A1_SIZE, A2_BASE, A2_SIZE,
                              mbox_word(8'd4)};
                program_windows();
            end
            send_item(plan[k].stim, plan[k].pinned, plan[k].want);
        end

        for (int p = 0; p < 5; p++) begin
            settle();
            span = rand64();
            case (p)
                0: cfg_words = '{A0_BASE, A0_SIZE, A1_BASE, A1_SIZE, A2_BASE, A2_SIZE,
                                 mbox_word(8'd4)};
                1: cfg_words = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, span, 64'h100, A2_BASE,
                                 A2_SIZE, mbox_word(8'hFF)};
                2: cfg_words = '{rand64(), XLEN'($urandom_range(1, 64)), rand64(),
                                 XLEN'($urandom_range(1, 64)), rand64(),
                                 XLEN'($urandom_range(1, 64)), mbox_word(8'd0)};
                3: cfg_words = '{rand64(), 64'h0, span, 64'h80, span + 64'h40, 64'h80,
                                 mbox_word(8'($urandom_range(1, 255)))};
                default: cfg_words = '{rand64(), 64'h1, rand64(),
                                       XLEN'($urandom_range(8, 4096)), rand64(),
                                       XLEN'($urandom_range(8, 4096)),
                                       mbox_word(8'($urandom_range(1, 16)))};
            endcase
            program_windows();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sender_idles   = (p < 4) && ((n / 20) % 2 == 0);
                receiver_idles = (p < 4) && (n % 40 >= 10);
                send_item(next_trap_item(), 1'b0, '0);
            end
        end
        settle();

        if (mismatches == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
